FILE: sv/ptc_pkg.sv
package ptc_pkg;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_QUERY = 4'd0;
    localparam kind_t KIND_PLAY  = 4'd1;
    localparam kind_t KIND_PAUSE = 4'd2;
    localparam kind_t KIND_STOP  = 4'd3;
    localparam kind_t KIND_SEEK  = 4'd4;
    localparam kind_t KIND_RATE  = 4'd5;
    localparam kind_t KIND_LOOP  = 4'd6;
    localparam kind_t KIND_CLEAR = 4'd7;
    localparam kind_t KIND_GO    = 4'd8;

    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_PAUSED  = 2'd1,
        RUN_PLAYING = 2'd2
    } run_t;

    localparam int          FD_W     = 30;
    localparam logic [29:0] FD_RESET = 30'd28224000;
    localparam int          USER_W   = 5;

    typedef struct packed {
        kind_t kind;
        logic  batched;
        logic  eot;
        logic  run_rec;
        logic  rate_bad;
        logic  region_bad;
    } ptc_class_t;

endpackage

FILE: sv/ptc_front.sv
module ptc_front #(
    parameter int FRAME_BITS   = 48,
    parameter int RATE_BITS    = 32,
    parameter int TRIGGER_BITS = 16
) (
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    input  logic [FRAME_BITS+2*RATE_BITS+TRIGGER_BITS+190:0]   s_item,
    input  logic [ptc_pkg::USER_W-1:0]                         s_tuser,
    input  logic                                               s_tlast,
    input  logic                                               q_full,
    output logic                                               q_push,
    output ptc_pkg::ptc_class_t                                q_cls
);
    import ptc_pkg::*;

    localparam int OFF_NUM = FRAME_BITS + 64;
    localparam int OFF_DEN = OFF_NUM + RATE_BITS;
    localparam int OFF_RS  = OFF_DEN + RATE_BITS - 1;
    localparam int OFF_RE  = OFF_RS + 64;

    logic [RATE_BITS-1:0] num;
    logic [RATE_BITS-2:0] den;
    logic [63:0]          rs;
    logic [63:0]          re;
    kind_t                kind;

    assign num  = s_item[OFF_NUM +: RATE_BITS];
    assign den  = s_item[OFF_DEN +: RATE_BITS-1];
    assign rs   = s_item[OFF_RS +: 64];
    assign re   = s_item[OFF_RE +: 64];
    assign kind = s_tuser[3:0];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cls            = '0;
        q_cls.kind       = kind;
        q_cls.batched    = s_tuser[4];
        q_cls.eot        = s_tlast;
        q_cls.run_rec    = s_tuser[4] && (kind inside {KIND_PLAY, KIND_PAUSE, KIND_STOP});
        q_cls.rate_bad   = (num == '0) || (den == '0);
        q_cls.region_bad = ($signed(re) <= $signed(rs));
    end

endmodule

FILE: sv/ptc_queue.sv
module ptc_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         rvalid,
    output logic [W-1:0] rdata
);
    logic [W-1:0] mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;

    assign full   = (cnt_reg == 2'd2);
    assign rvalid = (cnt_reg != 2'd0);
    assign rdata  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: sv/ptc_pos.sv
module ptc_pos #(
    parameter int FRAME_BITS = 48,
    parameter int RATE_BITS  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  ptc_pkg::run_t         mode,
    input  logic [63:0]           anchor_pos,
    input  logic [FRAME_BITS-1:0] anchor_frm,
    input  logic [FRAME_BITS-1:0] frame,
    input  logic [RATE_BITS-1:0]  speed_num,
    input  logic [RATE_BITS-2:0]  speed_den,
    input  logic                  loop_on,
    input  logic [63:0]           loop_lo,
    input  logic [63:0]           loop_hi,
    input  logic [29:0]           frame_duration,
    output logic                  done,
    output logic [63:0]           pos
);
    import ptc_pkg::*;

    localparam int PW = FRAME_BITS + FD_W + RATE_BITS;
    localparam int XW = PW + 2;
    localparam int MW = (FD_W > RATE_BITS) ? FD_W : RATE_BITS;
    localparam int CW = $clog2(XW + 1);

    typedef enum logic [6:0] {
        P_IDLE = 7'b0000001,
        P_MUL1 = 7'b0000010,
        P_MUL2 = 7'b0000100,
        P_DIV  = 7'b0001000,
        P_FIX  = 7'b0010000,
        P_MOD  = 7'b0100000,
        P_DONE = 7'b1000000
    } pstate_t;

    pstate_t              st_reg;
    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        mcand_reg;
    logic [MW-1:0]        mplier_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 neg_reg;
    logic                 xneg_reg;
    logic                 lp_reg;
    logic [XW-1:0]        quot_reg;
    logic [63:0]          rem_reg;
    logic [64:0]          base_reg;
    logic [63:0]          lo_reg;
    logic [63:0]          span_reg;
    logic [RATE_BITS-2:0] den_reg;
    logic [RATE_BITS-1:0] nmag_reg;
    logic [63:0]          pos_reg;

    logic [FRAME_BITS-1:0] emag;
    logic                  lp;
    logic [PW-1:0]         acc_add;
    logic                  msb_in;
    logic [64:0]           rem_sh;
    logic [63:0]           divisor;
    logic                  ge;
    logic [63:0]           rem_new;
    logic [XW-1:0]         basex;
    logic [XW-1:0]         qx;
    logic [XW-1:0]         x;
    logic                  fits;
    logic [63:0]           sat;
    logic [63:0]           tot;

    assign done = (st_reg == P_DONE);
    assign pos  = pos_reg;

    always_comb begin
        emag    = (frame >= anchor_frm) ? frame - anchor_frm : anchor_frm - frame;
        lp      = loop_on && ($signed(loop_hi) > $signed(loop_lo));
        acc_add = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
        msb_in  = (st_reg == P_MOD) ? quot_reg[XW-1] : quot_reg[PW-1];
        rem_sh  = {rem_reg, msb_in};
        divisor = (st_reg == P_MOD) ? span_reg : 64'(den_reg);
        ge      = (rem_sh >= {1'b0, divisor});
        rem_new = ge ? 64'(rem_sh - {1'b0, divisor}) : rem_sh[63:0];
        basex   = XW'($signed(base_reg));
        qx      = XW'(quot_reg[PW-1:0]);
        x       = neg_reg ? basex - qx : basex + qx;
        fits    = (&x[XW-1:63]) || !(|x[XW-1:63]);
        sat     = fits ? x[63:0] : (x[XW-1] ? 64'h8000_0000_0000_0000
                                            : 64'h7fff_ffff_ffff_ffff);
        tot     = (xneg_reg && (rem_new != '0)) ? span_reg - rem_new : rem_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= P_IDLE;
        end else begin
            case (st_reg)
                P_IDLE: begin
                    if (start) begin
                        if (mode != RUN_PLAYING) begin
                            pos_reg <= anchor_pos;
                            st_reg  <= P_DONE;
                        end else begin
                            neg_reg    <= (frame < anchor_frm) ^ speed_num[RATE_BITS-1];
                            nmag_reg   <= speed_num[RATE_BITS-1] ? -speed_num : speed_num;
                            den_reg    <= speed_den;
                            lp_reg     <= lp;
                            lo_reg     <= loop_lo;
                            span_reg   <= loop_hi - loop_lo;
                            base_reg   <= lp ? {anchor_pos[63], anchor_pos}
                                               - {loop_lo[63], loop_lo}
                                             : {anchor_pos[63], anchor_pos};
                            acc_reg    <= '0;
                            mcand_reg  <= PW'(emag);
                            mplier_reg <= MW'(frame_duration);
                            cnt_reg    <= CW'(FD_W);
                            st_reg     <= P_MUL1;
                        end
                    end
                end
                P_MUL1: begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        acc_reg    <= '0;
                        mcand_reg  <= acc_add;
                        mplier_reg <= MW'(nmag_reg);
                        cnt_reg    <= CW'(RATE_BITS);
                        st_reg     <= P_MUL2;
                    end
                end
                P_MUL2: begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        quot_reg <= XW'(acc_add);
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(PW);
                        st_reg   <= P_DIV;
                    end
                end
                P_DIV: begin
                    quot_reg <= {quot_reg[XW-2:0], ge};
                    rem_reg  <= rem_new;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= P_FIX;
                    end
                end
                P_FIX: begin
                    if (lp_reg) begin
                        quot_reg <= x[XW-1] ? -x : x;
                        xneg_reg <= x[XW-1];
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(XW);
                        st_reg   <= P_MOD;
                    end else begin
                        pos_reg <= sat;
                        st_reg  <= P_DONE;
                    end
                end
                P_MOD: begin
                    quot_reg <= {quot_reg[XW-2:0], ge};
                    rem_reg  <= rem_new;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        pos_reg <= lo_reg + tot;
                        st_reg  <= P_DONE;
                    end
                end
                P_DONE: begin
                    st_reg <= P_IDLE;
                end
                default: begin
                    st_reg <= P_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/ptc_back.sv
module ptc_back #(
    parameter int FRAME_BITS   = 48,
    parameter int RATE_BITS    = 32,
    parameter int TRIGGER_BITS = 16
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             q_valid,
    output logic                                             q_pop,
    input  logic [FRAME_BITS+2*RATE_BITS+TRIGGER_BITS+190:0] q_item,
    input  ptc_pkg::ptc_class_t                              q_cls,
    input  logic [29:0]                                      frame_duration,
    output logic                                             m_tvalid,
    input  logic                                             m_tready,
    output logic [((TRIGGER_BITS+69)+7)/8*8-1:0]             m_tdata
);
    import ptc_pkg::*;

    localparam int SD_W    = FRAME_BITS + 2 * RATE_BITS + TRIGGER_BITS + 191;
    localparam int MD_W    = ((TRIGGER_BITS + 69) + 7) / 8 * 8;
    localparam int OFF_SK  = FRAME_BITS;
    localparam int OFF_NUM = FRAME_BITS + 64;
    localparam int OFF_DEN = OFF_NUM + RATE_BITS;
    localparam int OFF_RS  = OFF_DEN + RATE_BITS - 1;
    localparam int OFF_RE  = OFF_RS + 64;
    localparam int OFF_TRG = OFF_RE + 64;
    localparam int PRD_W   = 2 * RATE_BITS - 1;

    typedef enum logic [8:0] {
        B_IDLE     = 9'b000000001,
        B_DISPATCH = 9'b000000010,
        B_REANCHOR = 9'b000000100,
        B_CMP_A    = 9'b000001000,
        B_CMP_B    = 9'b000010000,
        B_CMP_C    = 9'b000100000,
        B_TICK     = 9'b001000000,
        B_FINAL    = 9'b010000000,
        B_REPORT   = 9'b100000000
    } bstate_t;

    bstate_t              st_reg;
    run_t                 mode_reg;
    logic [63:0]          apos_reg;
    logic [FRAME_BITS-1:0] afrm_reg;
    logic [RATE_BITS-1:0] num_reg;
    logic [RATE_BITS-2:0] den_reg;
    logic                 lon_reg;
    logic [63:0]          llo_reg;
    logic [63:0]          lhi_reg;
    kind_t                pend_reg;
    logic                 tch_reg;
    logic [SD_W-1:0]      it_reg;
    ptc_class_t           cls_reg;
    logic                 ch_reg;
    logic                 ref_reg;
    logic                 fired_reg;
    logic                 second_reg;
    kind_t                akind_reg;
    logic [RATE_BITS-1:0] on_reg;
    logic [RATE_BITS-2:0] od_reg;
    logic [PRD_W-1:0]     prod_a_reg;
    logic [PRD_W-1:0]     prod_b_reg;
    logic                 mv_reg;
    logic [MD_W-1:0]      md_reg;
    logic                 emit_wait_reg;
    logic [63:0]          res_reg;

    logic [FRAME_BITS-1:0]   frame;
    logic [63:0]             seek;
    logic [RATE_BITS-1:0]    new_num;
    logic [RATE_BITS-2:0]    new_den;
    logic [63:0]             rs;
    logic [63:0]             re;
    logic [TRIGGER_BITS-1:0] trig;
    logic                    pstart;
    logic                    p_done;
    logic [63:0]             p_pos;
    logic [RATE_BITS-1:0]    mul_x;
    logic [RATE_BITS-2:0]    mul_y;
    logic [PRD_W-1:0]        product;
    logic                    tick_acc;
    logic                    out_free;

    assign frame   = it_reg[FRAME_BITS-1:0];
    assign seek    = it_reg[OFF_SK +: 64];
    assign new_num = it_reg[OFF_NUM +: RATE_BITS];
    assign new_den = it_reg[OFF_DEN +: RATE_BITS-1];
    assign rs      = it_reg[OFF_RS +: 64];
    assign re      = it_reg[OFF_RE +: 64];
    assign trig    = it_reg[OFF_TRG +: TRIGGER_BITS];

    assign q_pop    = (st_reg == B_IDLE) && q_valid && !emit_wait_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign tick_acc = tch_reg | ch_reg;
    assign out_free = !mv_reg || m_tready;

    always_comb begin
        pstart = 1'b0;
        case (st_reg)
            B_DISPATCH: begin
                pstart = !cls_reg.run_rec
                         && ((cls_reg.kind == KIND_PLAY) || (cls_reg.kind == KIND_PAUSE)
                             || ((cls_reg.kind == KIND_RATE) && !cls_reg.rate_bad));
            end
            B_TICK: begin
                pstart = cls_reg.batched && cls_reg.eot
                         && ((pend_reg == KIND_PLAY) || (pend_reg == KIND_PAUSE));
            end
            B_FINAL: begin
                pstart = 1'b1;
            end
            default: begin
                pstart = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (st_reg == B_CMP_A) begin
            mul_x = on_reg[RATE_BITS-1] ? -on_reg : on_reg;
            mul_y = den_reg;
        end else begin
            mul_x = num_reg[RATE_BITS-1] ? -num_reg : num_reg;
            mul_y = od_reg;
        end
        product = PRD_W'(mul_x) * PRD_W'(mul_y);
    end

    ptc_pos #(
        .FRAME_BITS (FRAME_BITS),
        .RATE_BITS  (RATE_BITS)
    ) u_pos (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (pstart),
        .mode           (mode_reg),
        .anchor_pos     (apos_reg),
        .anchor_frm     (afrm_reg),
        .frame          (frame),
        .speed_num      (num_reg),
        .speed_den      (den_reg),
        .loop_on        (lon_reg),
        .loop_lo        (llo_reg),
        .loop_hi        (lhi_reg),
        .frame_duration (frame_duration),
        .done           (p_done),
        .pos            (p_pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= B_IDLE;
            mode_reg      <= RUN_STOPPED;
            apos_reg      <= '0;
            afrm_reg      <= '0;
            num_reg       <= RATE_BITS'(1);
            den_reg       <= (RATE_BITS-1)'(1);
            lon_reg       <= 1'b0;
            llo_reg       <= '0;
            lhi_reg       <= '0;
            pend_reg      <= KIND_QUERY;
            tch_reg       <= 1'b0;
            mv_reg        <= 1'b0;
            emit_wait_reg <= 1'b0;
        end else begin
            if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end
            if (emit_wait_reg && out_free) begin
                mv_reg        <= 1'b1;
                emit_wait_reg <= 1'b0;
                md_reg        <= MD_W'({(fired_reg ? trig : TRIGGER_BITS'(0)), fired_reg,
                                        ref_reg, ch_reg, res_reg, mode_reg});
            end
            case (st_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        it_reg     <= q_item;
                        cls_reg    <= q_cls;
                        ch_reg     <= 1'b0;
                        ref_reg    <= 1'b0;
                        fired_reg  <= 1'b0;
                        second_reg <= 1'b0;
                        st_reg     <= B_DISPATCH;
                    end
                end
                B_DISPATCH: begin
                    st_reg <= B_TICK;
                    if (cls_reg.run_rec) begin
                        if (cls_reg.kind > pend_reg) begin
                            pend_reg <= cls_reg.kind;
                        end
                    end else begin
                        case (cls_reg.kind)
                            KIND_PLAY, KIND_PAUSE: begin
                                akind_reg <= cls_reg.kind;
                                st_reg    <= B_REANCHOR;
                            end
                            KIND_STOP: begin
                                ch_reg   <= (mode_reg != RUN_STOPPED) || (apos_reg != '0);
                                mode_reg <= RUN_STOPPED;
                                apos_reg <= '0;
                                afrm_reg <= frame;
                            end
                            KIND_SEEK: begin
                                ch_reg   <= (seek != apos_reg);
                                apos_reg <= seek;
                                afrm_reg <= frame;
                            end
                            KIND_RATE: begin
                                if (cls_reg.rate_bad) begin
                                    ref_reg <= 1'b1;
                                end else begin
                                    akind_reg <= KIND_RATE;
                                    st_reg    <= B_REANCHOR;
                                end
                            end
                            KIND_LOOP: begin
                                if (cls_reg.region_bad) begin
                                    ref_reg <= 1'b1;
                                end else begin
                                    ch_reg  <= !lon_reg || (llo_reg != rs) || (lhi_reg != re);
                                    lon_reg <= 1'b1;
                                    llo_reg <= rs;
                                    lhi_reg <= re;
                                end
                            end
                            KIND_CLEAR: begin
                                ch_reg  <= lon_reg;
                                lon_reg <= 1'b0;
                                llo_reg <= '0;
                                lhi_reg <= '0;
                            end
                            KIND_GO: begin
                                ch_reg    <= 1'b1;
                                fired_reg <= 1'b1;
                            end
                            default: begin
                                ch_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                B_REANCHOR: begin
                    if (p_done) begin
                        apos_reg <= p_pos;
                        afrm_reg <= frame;
                        case (akind_reg)
                            KIND_PLAY: begin
                                mode_reg <= RUN_PLAYING;
                                ch_reg   <= (second_reg & tch_reg) | (mode_reg != RUN_PLAYING)
                                            | (p_pos != apos_reg);
                            end
                            KIND_PAUSE: begin
                                mode_reg <= RUN_PAUSED;
                                ch_reg   <= (second_reg & tch_reg) | (mode_reg != RUN_PAUSED)
                                            | (p_pos != apos_reg);
                            end
                            default: begin
                                ch_reg  <= (p_pos != apos_reg);
                                on_reg  <= num_reg;
                                od_reg  <= den_reg;
                                num_reg <= new_num;
                                den_reg <= new_den;
                            end
                        endcase
                        if (akind_reg == KIND_RATE) begin
                            st_reg <= B_CMP_A;
                        end else if (second_reg) begin
                            tch_reg  <= 1'b0;
                            pend_reg <= KIND_QUERY;
                            st_reg   <= B_FINAL;
                        end else begin
                            st_reg <= B_TICK;
                        end
                    end
                end
                B_CMP_A: begin
                    prod_a_reg <= product;
                    st_reg     <= B_CMP_B;
                end
                B_CMP_B: begin
                    prod_b_reg <= product;
                    st_reg     <= B_CMP_C;
                end
                B_CMP_C: begin
                    ch_reg <= ch_reg | (on_reg[RATE_BITS-1] != num_reg[RATE_BITS-1])
                              | (prod_a_reg != prod_b_reg);
                    st_reg <= B_TICK;
                end
                B_TICK: begin
                    st_reg <= B_FINAL;
                    if (cls_reg.batched) begin
                        if (cls_reg.eot) begin
                            case (pend_reg)
                                KIND_PLAY, KIND_PAUSE: begin
                                    tch_reg    <= tick_acc;
                                    akind_reg  <= pend_reg;
                                    second_reg <= 1'b1;
                                    st_reg     <= B_REANCHOR;
                                end
                                KIND_STOP: begin
                                    ch_reg   <= tick_acc | (mode_reg != RUN_STOPPED)
                                                | (apos_reg != '0);
                                    mode_reg <= RUN_STOPPED;
                                    apos_reg <= '0;
                                    afrm_reg <= frame;
                                    tch_reg  <= 1'b0;
                                    pend_reg <= KIND_QUERY;
                                end
                                default: begin
                                    ch_reg   <= tick_acc;
                                    tch_reg  <= 1'b0;
                                    pend_reg <= KIND_QUERY;
                                end
                            endcase
                        end else begin
                            tch_reg <= tick_acc;
                        end
                    end
                end
                B_FINAL: begin
                    st_reg <= B_REPORT;
                end
                B_REPORT: begin
                    if (p_done) begin
                        res_reg       <= p_pos;
                        emit_wait_reg <= 1'b1;
                        st_reg        <= B_IDLE;
                    end
                end
                default: begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/playback_transport_controller.sv
// Playback transport: each request on the s_ channel yields exactly one result on the m_
// channel, in order. Requests are decoded and queued two deep ahead of a sequencer that
// runs them one at a time. The sequencer owns a bit-serial position unit: shift-add
// multiplies over the 30 frame-duration bits and the RATE_BITS rate bits, a restoring
// divide by the rate denominator over FRAME_BITS+RATE_BITS+30 product bits and, when a loop is
// set, a floor modulo over two more bits than that. A position is computed this way only
// while playing; otherwise the anchor position is returned directly. An unbatched play or
// pause and a valid rate take one position before the item's own result, and a batched
// tick end with a pending play or pause takes one more.
module playback_transport_controller #(
    parameter int FRAME_BITS   = 48,
    parameter int RATE_BITS    = 32,
    parameter int TRIGGER_BITS = 16
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    input  logic                                                      cfg_valid,
    output logic                                                      cfg_ready,
    input  logic [29:0]                                               cfg_data,
    input  logic                                                      s_tvalid,
    output logic                                                      s_tready,
    // frame, seek_position, rate_num, rate_den, region_start, region_end, trigger_id
    input  logic [((FRAME_BITS+2*RATE_BITS+TRIGGER_BITS+191)+7)/8*8-1:0] s_tdata,
    // kind, batched
    input  logic [ptc_pkg::USER_W-1:0]                                s_tuser,
    input  logic                                                      s_tlast,
    output logic                                                      m_tvalid,
    input  logic                                                      m_tready,
    // run_state, playhead, changed, refused, fired, fired_trigger
    output logic [((TRIGGER_BITS+69)+7)/8*8-1:0]                      m_tdata
);
    import ptc_pkg::*;

    localparam int SD_W    = FRAME_BITS + 2 * RATE_BITS + TRIGGER_BITS + 191;
    localparam int QW      = SD_W + $bits(ptc_class_t);
    localparam int M_REF   = 67;
    localparam int M_FIRED = 68;
    localparam int M_TRIG  = 69;

    logic [29:0]     fd_reg;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    ptc_class_t      f_cls;
    ptc_class_t      b_cls;
    logic [QW-1:0]   q_rdata;
    logic [SD_W-1:0] b_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg <= FD_RESET;
        end else if (cfg_valid) begin
            fd_reg <= cfg_data;
        end
    end

    ptc_front #(
        .FRAME_BITS   (FRAME_BITS),
        .RATE_BITS    (RATE_BITS),
        .TRIGGER_BITS (TRIGGER_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_tdata[SD_W-1:0]),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cls    (f_cls)
    );

    ptc_queue #(
        .W (QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({f_cls, s_tdata[SD_W-1:0]}),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    assign b_item = q_rdata[SD_W-1:0];
    assign b_cls  = q_rdata[QW-1:SD_W];

    ptc_back #(
        .FRAME_BITS   (FRAME_BITS),
        .RATE_BITS    (RATE_BITS),
        .TRIGGER_BITS (TRIGGER_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (b_item),
        .q_cls          (b_cls),
        .frame_duration (fd_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("request taken from an empty queue");

    a_trig_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_FIRED]) |-> (m_tdata[M_TRIG +: TRIGGER_BITS] == '0))
        else $error("trigger id reported without a go");

    a_ref_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_REF] && m_tdata[M_FIRED]))
        else $error("result both refused and fired");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ptc_pkg::*;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        kind_t                kind;
        logic [47:0]          frame;
        logic signed [63:0]   seek;
        logic signed [31:0]   rate_num;
        logic [30:0]          rate_den;
        logic signed [63:0]   reg_start;
        logic signed [63:0]   reg_end;
        logic [15:0]          trig;
        bit                   batched;
        bit                   eot;
    } request_t;

    typedef struct {
        run_t                 run;
        logic signed [63:0]   head;
        bit                   chg;
        bit                   refd;
        bit                   fire;
        logic [15:0]          trig;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [29:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [319:0] s_tdata = '0;
    logic [4:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;

    playback_transport_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // transport shadow
    run_t               tr_mode;
    logic signed [63:0] a_pos;
    logic [47:0]        a_frm;
    logic signed [31:0] sp_num;
    logic [30:0]        sp_den;
    bit                 loop_en;
    logic signed [63:0] lp_lo;
    logic signed [63:0] lp_hi;
    kind_t              pend_run;
    bit                 tick_chg;
    logic [29:0]        fd;

    outcome_t expected_results[$];
    int       errors = 0;
    int       src_idle_pct = 20;
    int       sink_idle_pct = 20;
    int       sink_hold = 0;
    logic [47:0] cur_frame = '0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] mag32(logic signed [31:0] n);
        logic [63:0] w;
        w = {{32{n[31]}}, n};
        return n[31] ? ~w + 64'd1 : w;
    endfunction

    function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a >= m - b) ? a - (m - b) : a + b;
    endfunction

    function automatic logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic logic signed [63:0] playhead_at(logic [47:0] f);
        bit           neg;
        logic [47:0]  emag;
        logic [191:0] prod;
        logic [191:0] quo;
        logic [63:0]  ua, span, ulo, dm, r, tot, q64;
        if (tr_mode != RUN_PLAYING) return a_pos;
        neg  = f < a_frm;
        emag = neg ? a_frm - f : f - a_frm;
        if (sp_num < 0) neg = !neg;
        prod = emag;
        prod = prod * fd;
        prod = prod * mag32(sp_num);
        quo  = prod / sp_den;
        ua   = a_pos ^ SIGN64;
        if (loop_en && lp_hi > lp_lo) begin
            span = lp_hi - lp_lo;
            ulo  = lp_lo ^ SIGN64;
            dm   = sub_mod(ua % span, ulo % span, span);
            r    = quo % span;
            tot  = neg ? sub_mod(dm, r, span) : add_mod(dm, r, span);
            return lp_lo + tot;
        end
        if (quo[191:64] != '0) return neg ? POS_MIN : POS_MAX;
        q64 = quo[63:0];
        if (neg) return (q64 > ua) ? POS_MIN : $signed((ua - q64) ^ SIGN64);
        return (q64 > ~ua) ? POS_MAX : $signed((ua + q64) ^ SIGN64);
    endfunction

    function automatic bit same_speed(logic signed [31:0] n0, logic [30:0] d0,
                                      logic signed [31:0] n1, logic [30:0] d1);
        logic [127:0] x, y;
        if ((n0 < 0) != (n1 < 0)) return 1'b0;
        x = mag32(n0);
        x = x * d1;
        y = mag32(n1);
        y = y * d0;
        return x == y;
    endfunction

    function automatic void reanchor(logic [47:0] f);
        a_pos = playhead_at(f);
        a_frm = f;
    endfunction

    function automatic bit apply_cmd(kind_t k, request_t q, output bit refd,
                                     output bit fire, output logic [15:0] tg);
        run_t               m0;
        logic signed [63:0] p0, lo0, hi0;
        logic signed [31:0] n0;
        logic [30:0]        d0;
        bit                 l0;
        m0 = tr_mode; p0 = a_pos; n0 = sp_num; d0 = sp_den;
        l0 = loop_en; lo0 = lp_lo; hi0 = lp_hi;
        refd = 1'b0; fire = 1'b0; tg = '0;
        case (k)
            KIND_PLAY: begin
                reanchor(q.frame);
                tr_mode = RUN_PLAYING;
            end
            KIND_PAUSE: begin
                reanchor(q.frame);
                tr_mode = RUN_PAUSED;
            end
            KIND_STOP: begin
                tr_mode = RUN_STOPPED;
                a_pos = '0;
                a_frm = q.frame;
            end
            KIND_SEEK: begin
                a_pos = q.seek;
                a_frm = q.frame;
            end
            KIND_RATE: begin
                if (q.rate_num == 0 || q.rate_den == 0) begin
                    refd = 1'b1;
                    return 1'b0;
                end
                reanchor(q.frame);
                sp_num = q.rate_num;
                sp_den = q.rate_den;
            end
            KIND_LOOP: begin
                if (q.reg_end <= q.reg_start) begin
                    refd = 1'b1;
                    return 1'b0;
                end
                loop_en = 1'b1;
                lp_lo = q.reg_start;
                lp_hi = q.reg_end;
            end
            KIND_CLEAR: begin
                loop_en = 1'b0;
                lp_lo = '0;
                lp_hi = '0;
            end
            KIND_GO: begin
                fire = 1'b1;
                tg = q.trig;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
        return tr_mode != m0 || a_pos != p0 || !same_speed(n0, d0, sp_num, sp_den) ||
               loop_en != l0 || (l0 && (lp_lo != lo0 || lp_hi != hi0));
    endfunction

    function automatic void reset_transport();
        tr_mode = RUN_STOPPED;
        a_pos = '0; a_frm = '0;
        sp_num = 32'sd1; sp_den = 31'd1;
        loop_en = 1'b0; lp_lo = '0; lp_hi = '0;
        pend_run = KIND_QUERY; tick_chg = 1'b0;
        fd = FD_RESET;
    endfunction

    function automatic outcome_t predict_transport(request_t q);
        outcome_t    o;
        bit          ch, r2, f2;
        logic [15:0] t2;
        ch = 1'b0;
        o.refd = 1'b0; o.fire = 1'b0; o.trig = '0;
        if (q.batched && q.kind >= KIND_PLAY && q.kind <= KIND_STOP) begin
            if (q.kind > pend_run) pend_run = q.kind;
        end else begin
            ch = apply_cmd(q.kind, q, o.refd, o.fire, o.trig);
        end
        if (q.batched) begin
            tick_chg = tick_chg || ch;
            if (q.eot) begin
                if (pend_run != KIND_QUERY)
                    if (apply_cmd(pend_run, q, r2, f2, t2)) tick_chg = 1'b1;
                ch = tick_chg;
                tick_chg = 1'b0;
                pend_run = KIND_QUERY;
            end
        end
        o.run = tr_mode;
        o.head = playhead_at(q.frame);
        o.chg = ch;
        return o;
    endfunction

    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            m_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < sink_idle_pct) sink_hold <= idle_len();
        end
    end

    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[1:0] != e.run) begin
                    $display("%0t: run_state exp %0d got %0d", $realtime, e.run, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[65:2] != e.head) begin
                    $display("%0t: playhead exp %0d got %0d", $realtime, e.head,
                             $signed(m_tdata[65:2]));
                    errors++;
                end
                if (m_tdata[66] != e.chg) begin
                    $display("%0t: changed exp %0b got %0b", $realtime, e.chg, m_tdata[66]);
                    errors++;
                end
                if (m_tdata[67] != e.refd) begin
                    $display("%0t: refused exp %0b got %0b", $realtime, e.refd, m_tdata[67]);
                    errors++;
                end
                if (m_tdata[68] != e.fire) begin
                    $display("%0t: fired exp %0b got %0b", $realtime, e.fire, m_tdata[68]);
                    errors++;
                end
                if (m_tdata[84:69] != e.trig) begin
                    $display("%0t: fired_trigger exp %h got %h", $realtime, e.trig,
                             m_tdata[84:69]);
                    errors++;
                end
            end
        end
    end

    task automatic send_request(request_t q);
        int gap;
        gap = ($urandom_range(0, 99) < src_idle_pct) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, q.trig, q.reg_end, q.reg_start, q.rate_den, q.rate_num,
                     q.seek, q.frame};
        s_tuser  <= {q.batched, q.kind};
        s_tlast  <= q.eot;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_transport(q));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_frame_duration(logic [29:0] v);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        fd = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic request_t noise_request(kind_t k, logic [47:0] f);
        request_t q;
        q.kind      = k;
        q.frame     = f;
        q.seek      = {$urandom, $urandom};
        q.rate_num  = $urandom;
        q.rate_den  = $urandom;
        q.reg_start = {$urandom, $urandom};
        q.reg_end   = {$urandom, $urandom};
        q.trig      = $urandom;
        q.batched   = 1'b0;
        q.eot       = 1'b0;
        return q;
    endfunction

    function automatic logic signed [63:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return {$urandom, $urandom};
            default: return (longint'($urandom_range(0, 2000)) - 1000) * 64'sd14112000;
        endcase
    endfunction

    task automatic directed_cmd(kind_t k, logic [47:0] f, bit b = 0, bit e = 0);
        request_t q;
        q = noise_request(k, f);
        q.batched = b;
        q.eot = e;
        send_request(q);
    endtask

    task automatic test_directed();
        request_t q;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        directed_cmd(KIND_QUERY, 48'd0);
        directed_cmd(KIND_PLAY, 48'd10);
        directed_cmd(KIND_QUERY, 48'd130);
        q = noise_request(KIND_RATE, 48'd140);
        q.rate_num = 0; q.rate_den = 31'd5;
        send_request(q);
        q.rate_num = 32'sd3; q.rate_den = 31'd0;
        send_request(q);
        q.rate_num = 32'sd2; q.rate_den = 31'd2;
        send_request(q);
        q.rate_num = 32'sh8000_0000; q.rate_den = 31'h7FFF_FFFF;
        send_request(q);
        q = noise_request(KIND_LOOP, 48'd150);
        q.reg_start = 64'sd5000; q.reg_end = 64'sd5000;
        send_request(q);
        q.reg_start = 64'sd0; q.reg_end = 64'sd282240000;
        send_request(q);
        directed_cmd(KIND_QUERY, 48'hFFFF_FFFF_FFFF);
        q = noise_request(KIND_GO, 48'd160);
        q.trig = 16'hFFFF;
        send_request(q);
        q.trig = 16'h0000;
        send_request(q);
        directed_cmd(KIND_CLEAR, 48'd170);
        q = noise_request(KIND_SEEK, 48'd170);
        q.seek = POS_MIN;
        send_request(q);
        directed_cmd(KIND_QUERY, 48'h8000_0000_0000);
        q = noise_request(KIND_RATE, 48'd180);
        q.rate_num = 32'sh7FFF_FFFF; q.rate_den = 31'd1;
        send_request(q);
        q = noise_request(KIND_SEEK, 48'd180);
        q.seek = POS_MAX;
        send_request(q);
        directed_cmd(KIND_QUERY, 48'hFFFF_FFFF_FFFF);
        directed_cmd(kind_t'(4'd15), 48'd200);
        directed_cmd(KIND_PAUSE, 48'd210, 0, 1);
        directed_cmd(KIND_PLAY, 48'd220, 1, 0);
        directed_cmd(KIND_PAUSE, 48'd220, 1, 0);
        directed_cmd(KIND_SEEK, 48'd221, 1, 0);
        directed_cmd(KIND_QUERY, 48'd222, 0, 0);
        directed_cmd(KIND_QUERY, 48'd223, 1, 1);
        directed_cmd(KIND_STOP, 48'd230);
    endtask

    function automatic kind_t pick_kind(bit in_tick);
        int r;
        r = $urandom_range(0, 99);
        if (in_tick && r < 45) return kind_t'($urandom_range(1, 3));
        if (r < 12) return KIND_QUERY;
        if (r < 28) return KIND_PLAY;
        if (r < 36) return KIND_PAUSE;
        if (r < 41) return KIND_STOP;
        if (r < 52) return KIND_SEEK;
        if (r < 66) return KIND_RATE;
        if (r < 78) return KIND_LOOP;
        if (r < 83) return KIND_CLEAR;
        if (r < 96) return KIND_GO;
        return kind_t'($urandom_range(9, 15));
    endfunction

    task automatic test_random(int n);
        request_t q;
        int       tick_left;
        int       r;
        tick_left = 0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) cur_frame = {$urandom, $urandom};
            else if (r < 6) cur_frame = cur_frame - $urandom_range(1, 50);
            else cur_frame = cur_frame + $urandom_range(0, 4);
            if (tick_left == 0 && $urandom_range(0, 99) < 25) tick_left = $urandom_range(1, 5);
            q = noise_request(pick_kind(tick_left != 0), cur_frame);
            if (tick_left != 0 && $urandom_range(0, 99) >= 10) begin
                q.batched = 1'b1;
                q.eot = (tick_left == 1);
                tick_left--;
            end else begin
                q.eot = ($urandom_range(0, 99) < 5);
            end
            case (q.kind)
                KIND_SEEK: q.seek = pick_pos();
                KIND_RATE: begin
                    r = $urandom_range(0, 99);
                    if (r < 80) begin
                        q.rate_num = $urandom_range(1, 4);
                        if ($urandom_range(0, 1)) q.rate_num = -q.rate_num;
                        q.rate_den = $urandom_range(1, 4);
                    end else if (r < 85) begin
                        q.rate_num = 0;
                    end else if (r < 90) begin
                        q.rate_den = 0;
                    end
                end
                KIND_LOOP: begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        q.reg_start = pick_pos();
                        q.reg_end = q.reg_start + $urandom_range(1, 2_000_000_000);
                        if (q.reg_end <= q.reg_start) q.reg_start = q.reg_end - 1;
                    end else if (r < 85) begin
                        q.reg_end = q.reg_start - $urandom_range(0, 3);
                        if (q.reg_end > q.reg_start) q.reg_end = q.reg_start;
                    end
                end
                default: ;
            endcase
            send_request(q);
        end
    endtask

    task automatic test_phase(int src, int sink, int n);
        src_idle_pct = src;
        sink_idle_pct = sink;
        test_random(n);
    endtask

    initial begin
        reset_transport();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_phase(20, 20, 205);
        write_frame_duration(30'd1);
        test_phase(0, 0, 205);
        write_frame_duration(30'd705600000);
        test_phase(40, 10, 205);
        write_frame_duration(30'd0);
        test_phase(10, 40, 205);
        write_frame_duration(30'h3FFF_FFFF);
        test_phase(25, 25, 105);
        write_frame_duration(FD_RESET);
        test_phase(15, 15, 100);
        drain();
        repeat (1000) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/ptc_pkg.sv
sv/ptc_front.sv
sv/ptc_queue.sv
sv/ptc_pos.sv
sv/ptc_back.sv
sv/playback_transport_controller.sv
bench/tb_top.sv
